[design/ccr_pkg.sv]
`default_nettype none

package ccr_pkg;

    localparam int SampleW = 10;
    localparam int DriveW  = 16;
    localparam int TargetW = 14;
    localparam int ModeW   = 8;
    localparam int OffsetW = 8;
    localparam int PhaseW  = 2;
    localparam int SlopeW  = 3;
    localparam int PauseW  = 5;

    localparam int InDataW  = 16;
    localparam int OutDataW = 24;
    localparam int AddrW    = 4;
    localparam int DataW    = 32;

    localparam logic [SampleW-1:0] PumpLimit  = 10'd794;
    localparam logic [SampleW-1:0] WaitLimit  = 10'd744;
    localparam logic [SampleW-1:0] TopupLimit = 10'd868;
    localparam logic [SlopeW-1:0]  SlopeMax   = 3'd6;
    localparam logic [PauseW-1:0]  PauseShort = 5'd10;
    localparam logic [PauseW-1:0]  PauseLong  = 5'd20;
    localparam logic [PauseW-1:0]  PauseSat   = 5'd31;

    localparam logic [TargetW-1:0] TargetReset = 14'd10;
    localparam logic [ModeW-1:0]   ModeReset   = 8'd0;
    localparam logic [OffsetW-1:0] OffsetReset = 8'd4;

    localparam logic [ModeW-1:0] ModeTrack  = 8'd1;
    localparam logic [ModeW-1:0] ModeSearch = 8'd2;

    typedef enum logic [1:0] {
        REG_TARGET = 2'd0,
        REG_MODE   = 2'd1,
        REG_OFFSET = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    typedef enum logic [PhaseW-1:0] {
        PH_PUMP  = 2'd0,
        PH_PAUSE = 2'd1,
        PH_WAIT  = 2'd2,
        PH_TOPUP = 2'd3
    } phase_t;

endpackage

`default_nettype wire

[design/charge_current_regulator_core.sv]
`default_nettype none

// Channel   Direction  tdata fields (lowest bit up)                     tuser
// s_        in         battery_sample[9:0], start_charge[10], zero pad   -
// m_        out        pwm_compare[15:0], search_phase[17:16], zero pad  -
// apb       in         target_current @0x0, regulation_mode @0x4,
//                      drive_offset @0x8
//
// One transaction per cycle unless stalled; result registered on acceptance.
// The state update and the result register sit behind one short add/compare path.
// Reset is synchronous (aresetn low) and resets all registers but m_tdata_reg.
// A stalled result holds in the output register; s_tready drops only while it waits.

module charge_current_regulator_core (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // battery_sample[9:0], start_charge[10]
    input  wire  [ccr_pkg::InDataW-1:0]      s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // pwm_compare[15:0], search_phase[17:16]
    output logic [ccr_pkg::OutDataW-1:0]     m_tdata,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [ccr_pkg::AddrW-1:0]        paddr,
    input  wire  [ccr_pkg::DataW-1:0]        pwdata,
    output logic [ccr_pkg::DataW-1:0]        prdata,
    output logic                             pready
);
    import ccr_pkg::*;

    logic [TargetW-1:0] target_reg;
    logic [ModeW-1:0]   mode_reg;
    logic [OffsetW-1:0] offset_reg;

    logic [SampleW-1:0] prev_reg, prev_next;
    logic [DriveW-1:0]  drive_reg, drive_next;
    phase_t             phase_reg, phase_next;
    logic [SlopeW-1:0]  slope_reg, slope_next;
    logic [PauseW-1:0]  pause_reg, pause_next;

    logic               m_tvalid_reg;
    logic [OutDataW-1:0] m_tdata_reg;

    reg_idx_t           cfg_idx;
    logic               cfg_wr;
    logic               s_fire;

    logic [SampleW-1:0] sample;
    logic               start;
    logic [SampleW-1:0] prev_eff;
    logic [DriveW-1:0]  drive_eff;
    phase_t             phase_eff;
    logic [SlopeW-1:0]  slope_eff;
    logic [PauseW-1:0]  pause_eff;
    logic signed [SampleW:0]   diff;
    logic signed [SampleW+1:0] pump_add;
    logic signed [SampleW+1:0] topup_add;
    logic [DriveW-1:0]  target;
    logic [SlopeW-1:0]  slope_inc;
    logic [PauseW-1:0]  pause_inc;
    logic [DriveW-1:0]  pwm;

    assign pready   = 1'b1;
    assign cfg_idx  = reg_idx_t'(paddr[3:2]);
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_TARGET: prdata = {{(DataW-TargetW){1'b0}}, target_reg};
            REG_MODE:   prdata = {{(DataW-ModeW){1'b0}}, mode_reg};
            REG_OFFSET: prdata = {{(DataW-OffsetW){1'b0}}, offset_reg};
            default:    prdata = '0;
        endcase
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign sample    = s_tdata[SampleW-1:0];
    assign start     = s_tdata[SampleW];
    assign prev_eff  = start ? sample : prev_reg;
    assign drive_eff = start ? '0 : drive_reg;
    assign phase_eff = start ? PH_PUMP : phase_reg;
    assign slope_eff = start ? '0 : slope_reg;
    assign pause_eff = start ? '0 : pause_reg;

    assign diff      = $signed({1'b0, sample}) - $signed({1'b0, prev_eff});
    assign pump_add  = 12'sd1 - {diff[SampleW], diff};
    assign topup_add = 12'sd3 - {diff[SampleW], diff};
    assign target    = {{(DriveW-TargetW-1){1'b0}}, target_reg, 1'b0};
    assign slope_inc = slope_eff + 3'd1;
    assign pause_inc = (pause_eff < PauseSat) ? pause_eff + 5'd1 : pause_eff;

    always_comb begin
        drive_next = drive_eff;
        phase_next = phase_eff;
        slope_next = slope_eff;
        pause_next = pause_eff;
        prev_next  = sample;
        if (mode_reg == ModeTrack) begin
            if (drive_eff > target) begin
                drive_next = drive_eff - 16'd1;
            end else if (drive_eff < target) begin
                drive_next = drive_eff + 16'd1;
            end
        end else if (mode_reg == ModeSearch) begin
            unique case (phase_eff)
                PH_PUMP: begin
                    if (sample < PumpLimit) begin
                        if (diff < 11'sd1) begin
                            drive_next = drive_eff + {5'd0, pump_add[SampleW:0]};
                            slope_next = slope_inc;
                            if (slope_inc > SlopeMax) begin
                                phase_next = PH_WAIT;
                                drive_next = '0;
                                slope_next = '0;
                            end
                        end else begin
                            slope_next = '0;
                        end
                    end else begin
                        phase_next = PH_PAUSE;
                        pause_next = '0;
                    end
                end
                PH_PAUSE: begin
                    if (pause_eff < PauseShort) begin
                        pause_next = pause_inc;
                    end else begin
                        drive_next = '0;
                        phase_next = PH_WAIT;
                        pause_next = '0;
                    end
                end
                PH_WAIT: begin
                    if (sample >= WaitLimit) begin
                        pause_next = pause_inc;
                        if (pause_inc > PauseLong) begin
                            phase_next = PH_TOPUP;
                        end
                    end else if (diff >= 11'sd0) begin
                        slope_next = slope_inc;
                        if (slope_inc > SlopeMax) begin
                            phase_next = PH_PUMP;
                            slope_next = '0;
                        end
                    end else begin
                        slope_next = '0;
                    end
                end
                PH_TOPUP: begin
                    if (sample < TopupLimit && diff < 11'sd3) begin
                        drive_next = drive_eff + {5'd0, topup_add[SampleW:0]};
                    end
                end
                default: begin
                    phase_next = phase_eff;
                end
            endcase
        end else begin
            drive_next = target;
        end
    end

    assign pwm = drive_next + {{(DriveW-OffsetW){1'b0}}, offset_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= TargetReset;
            mode_reg     <= ModeReset;
            offset_reg   <= OffsetReset;
            prev_reg     <= '0;
            drive_reg    <= '0;
            phase_reg    <= PH_PUMP;
            slope_reg    <= '0;
            pause_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_TARGET: target_reg <= pwdata[TargetW-1:0];
                    REG_MODE:   mode_reg   <= pwdata[ModeW-1:0];
                    REG_OFFSET: offset_reg <= pwdata[OffsetW-1:0];
                    default:    target_reg <= target_reg;
                endcase
            end
            if (s_fire) begin
                prev_reg     <= prev_next;
                drive_reg    <= drive_next;
                phase_reg    <= phase_next;
                slope_reg    <= slope_next;
                pause_reg    <= pause_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= {{(OutDataW-DriveW-PhaseW){1'b0}}, phase_next, pwm};
        end
    end

`ifndef ASSERT_OFF
    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_start_pump_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && start && mode_reg != ModeSearch |=> m_tdata[17:16] == PH_PUMP)
        else $error("start transaction left search phase set");

    a_fixed_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && mode_reg != ModeTrack && mode_reg != ModeSearch
        |=> m_tdata[15:0] == $past(target + {8'd0, offset_reg}))
        else $error("fixed drive result mismatch");

    a_state_moves_on_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(drive_reg) && $stable(prev_reg))
        else $error("regulator state changed without a transaction");
`endif

endmodule

`default_nettype wire

[tb/sv/charge_current_regulator_core_tb.sv]
`timescale 1ns / 100ps

module charge_current_regulator_core_tb;

    import ccr_pkg::*;

    localparam int CycleLimit = 400000;

    typedef struct packed {
        logic [DriveW-1:0] pwm;
        phase_t            ph;
    } compare_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // battery_sample[9:0], start_charge[10], zero pad
    logic [InDataW-1:0]   s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    // pwm_compare[15:0], search_phase[17:16], zero pad
    logic [OutDataW-1:0]  m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AddrW-1:0]     paddr;
    logic [DataW-1:0]     pwdata;
    logic [DataW-1:0]     prdata;
    logic                 pready;

    logic [TargetW-1:0]   cfg_target = TargetReset;
    logic [ModeW-1:0]     cfg_mode   = ModeReset;
    logic [OffsetW-1:0]   cfg_offset = OffsetReset;
    logic [SampleW-1:0]   last_sample = '0;
    logic [DriveW-1:0]    drive = '0;
    phase_t               search_ph = PH_PUMP;
    logic [SlopeW-1:0]    slope_cnt = '0;
    logic [PauseW-1:0]    pause_cnt = '0;

    compare_t             expected_compares[$];
    compare_t             head;
    int                   samples_taken = 0;
    int                   cfg_writes = 0;
    int                   items_sent = 0;
    int                   fail_count = 0;
    int                   cycle_cnt = 0;
    int                   stall_left = 0;
    bit                   gaps_on = 1'b0;
    bit                   stalls_on = 1'b0;

    charge_current_regulator_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void step_regulator(input logic [SampleW-1:0] smp, input logic st);
        int                diff;
        logic [DriveW-1:0] goal;
        goal = {1'b0, cfg_target, 1'b0};
        if (st) begin
            drive = '0;
            search_ph = PH_PUMP;
            slope_cnt = '0;
            pause_cnt = '0;
            last_sample = smp;
        end
        diff = int'(smp) - int'(last_sample);
        if (cfg_mode == ModeTrack) begin
            if (drive > goal) drive--;
            if (drive < goal) drive++;
        end else if (cfg_mode == ModeSearch) begin
            case (search_ph)
                PH_PUMP: begin
                    if (smp < PumpLimit) begin
                        if (diff < 1) begin
                            drive = drive + DriveW'(1 - diff);
                            slope_cnt++;
                            if (slope_cnt > SlopeMax) begin
                                search_ph = PH_WAIT;
                                drive = '0;
                                slope_cnt = '0;
                            end
                        end else begin
                            slope_cnt = '0;
                        end
                    end else begin
                        search_ph = PH_PAUSE;
                        pause_cnt = '0;
                    end
                end
                PH_PAUSE: begin
                    if (pause_cnt < PauseShort) begin
                        if (pause_cnt != PauseSat) pause_cnt++;
                    end else begin
                        drive = '0;
                        search_ph = PH_WAIT;
                        pause_cnt = '0;
                    end
                end
                PH_WAIT: begin
                    if (smp >= WaitLimit) begin
                        if (pause_cnt != PauseSat) pause_cnt++;
                        if (pause_cnt > PauseLong) search_ph = PH_TOPUP;
                    end else if (diff >= 0) begin
                        slope_cnt++;
                        if (slope_cnt > SlopeMax) begin
                            search_ph = PH_PUMP;
                            slope_cnt = '0;
                        end
                    end else begin
                        slope_cnt = '0;
                    end
                end
                default: begin
                    if (smp < TopupLimit && diff < 3) drive = drive + DriveW'(3 - diff);
                end
            endcase
        end else begin
            drive = goal;
        end
        last_sample = smp;
        expected_compares.push_back('{pwm: drive + DriveW'(cfg_offset), ph: search_ph});
    endfunction

    // check results first, then take new samples and register writes
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_compares.size() == 0) begin
                $error("result with none pending: m_tdata %h", m_tdata);
                fail_count++;
            end else begin
                head = expected_compares.pop_front();
                if (m_tdata[15:0] !== head.pwm) begin
                    $error("pwm_compare: expected %0d, actual %0d", head.pwm, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[17:16] !== head.ph) begin
                    $error("search_phase: expected %0d, actual %0d", head.ph, m_tdata[17:16]);
                    fail_count++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            step_regulator(s_tdata[SampleW-1:0], s_tdata[SampleW]);
            samples_taken++;
        end
        if (aresetn && psel && penable && pwrite && pready) begin
            case (reg_idx_t'(paddr[AddrW-1:2]))
                REG_TARGET: cfg_target = pwdata[TargetW-1:0];
                REG_MODE:   cfg_mode   = pwdata[ModeW-1:0];
                REG_OFFSET: cfg_offset = pwdata[OffsetW-1:0];
                default:    ;
            endcase
            cfg_writes++;
        end
    end

    always @(negedge aclk) begin
        if (!stalls_on) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [SampleW-1:0] smp, input logic st);
        int n0;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        n0 = samples_taken;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(InDataW-SampleW-1){1'b0}}, st, smp};
        do @(negedge aclk); while (samples_taken == n0);
        items_sent++;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DataW-1:0] val);
        int n0;
        n0 = cfg_writes;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (cfg_writes == n0);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (expected_compares.size() != 0);
        repeat (2) @(negedge aclk);
    endtask

    function automatic logic [SampleW-1:0] next_level(input logic [SampleW-1:0] cur,
                                                      input int bias);
        int v;
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            v = $urandom_range(0, 1023);
        end else if (r < 12) begin
            case ($urandom_range(0, 3))
                0:       v = int'(PumpLimit);
                1:       v = int'(WaitLimit);
                2:       v = int'(TopupLimit);
                default: v = $urandom_range(0, 1) * 1023;
            endcase
            v = v + int'($urandom_range(0, 2)) - 1;
        end else begin
            v = int'(cur) + int'($urandom_range(0, 6)) - 3 + bias;
        end
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return SampleW'(v);
    endfunction

    task automatic test_reset_values();
        send_sample(10'd0, 1'b0);
        send_sample(10'd1023, 1'b0);
        send_sample(10'd512, 1'b1);
        wait_drained();
    endtask

    task automatic test_fixed_drive();
        write_reg(REG_TARGET, 32'hFFFF_C000);
        write_reg(REG_OFFSET, 32'd0);
        write_reg(REG_MODE, 32'd0);
        send_sample(10'd0, 1'b0);
        wait_drained();
        write_reg(REG_TARGET, 32'd9990);
        write_reg(REG_OFFSET, 32'd255);
        write_reg(REG_MODE, 32'd255);
        send_sample(10'd1023, 1'b1);
        wait_drained();
        write_reg(REG_TARGET, 32'h0000_3FFF);
        write_reg(REG_MODE, 32'hFFFF_FF03);
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        send_sample(10'd341, 1'b0);
        wait_drained();
    endtask

    task automatic test_tracking();
        write_reg(REG_TARGET, 32'd3);
        write_reg(REG_OFFSET, 32'd0);
        write_reg(REG_MODE, {24'd0, ModeTrack});
        send_sample(10'd100, 1'b1);
        send_sample(10'd200, 1'b0);
        send_sample(10'd300, 1'b0);
        send_sample(10'd400, 1'b0);
        wait_drained();
        write_reg(REG_TARGET, 32'd1);
        send_sample(10'd0, 1'b0);
        send_sample(10'd0, 1'b0);
        wait_drained();
    endtask

    task automatic test_search_entry();
        write_reg(REG_OFFSET, 32'd4);
        write_reg(REG_MODE, {24'd0, ModeSearch});
        send_sample(10'd800, 1'b1);
        send_sample(10'd793, 1'b1);
        send_sample(10'd0, 1'b0);
        send_sample(10'd1023, 1'b0);
        wait_drained();
    endtask

    task automatic test_search_walks(input int quota);
        int                 stop_at;
        int                 len;
        int                 bias;
        logic [ModeW-1:0]   mode;
        logic [TargetW-1:0] tgt;
        logic [OffsetW-1:0] ofs;
        logic [SampleW-1:0] level;
        logic               lead_start;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            wait_drained();
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: mode = ModeSearch;
                6, 7:             mode = ModeTrack;
                8:                mode = '0;
                default:          mode = ModeW'($urandom_range(3, 255));
            endcase
            case ($urandom_range(0, 9))
                0:       tgt = '0;
                1:       tgt = 14'd9990;
                2:       tgt = '1;
                default: tgt = (mode == ModeTrack) ? TargetW'($urandom_range(0, 40))
                                                   : TargetW'($urandom_range(0, 9990));
            endcase
            case ($urandom_range(0, 9))
                0:       ofs = '0;
                1:       ofs = '1;
                default: ofs = OffsetW'($urandom);
            endcase
            write_reg(REG_TARGET, ($urandom_range(0, 3) == 0 ? $urandom & 32'hFFFF_C000 : 0)
                                  | DataW'(tgt));
            write_reg(REG_OFFSET, ($urandom_range(0, 3) == 0 ? $urandom & 32'hFFFF_FF00 : 0)
                                  | DataW'(ofs));
            write_reg(REG_MODE, ($urandom_range(0, 3) == 0 ? $urandom & 32'hFFFF_FF00 : 0)
                                | DataW'(mode));
            if ($urandom_range(0, 9) == 0) write_reg(REG_NONE, $urandom);
            if (mode == ModeSearch) begin
                len = $urandom_range(20, 120);
                lead_start = $urandom_range(0, 9) < 7;
            end else begin
                len = $urandom_range(5, 40);
                lead_start = $urandom_range(0, 9) < 3;
            end
            level = SampleW'($urandom_range(600, 900));
            bias = 0;
            for (int k = 0; k < len; k++) begin
                if (k % 10 == 0) bias = int'($urandom_range(0, 5)) - 3;
                level = next_level(level, bias);
                send_sample(level, (k == 0) ? lead_start : ($urandom_range(0, 49) == 0));
            end
        end
    endtask

    task automatic test_drive_wrap();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        wait_drained();
        write_reg(REG_OFFSET, 32'd255);
        write_reg(REG_MODE, {24'd0, ModeSearch});
        // enter pause, wait it out, then hold high until top-up
        send_sample(SampleW'($urandom_range(794, 1023)), 1'b1);
        repeat (11) send_sample(SampleW'($urandom), 1'b0);
        repeat (21) send_sample(SampleW'($urandom_range(744, 1023)), 1'b0);
        // swing the sample to pump the drive past its wrap
        repeat (80) begin
            send_sample(SampleW'($urandom_range(868, 1023)), 1'b0);
            send_sample(SampleW'($urandom_range(0, 20)), 1'b0);
        end
        wait_drained();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_values();
        test_fixed_drive();
        test_tracking();
        test_search_entry();
        test_search_walks(1750);
        test_drive_wrap();
        repeat (4) @(negedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[charge_current_regulator_core.f]
design/ccr_pkg.sv
design/charge_current_regulator_core.sv
tb/sv/charge_current_regulator_core_tb.sv
